/* hw/rtl/fbsc_pkg.sv */
// ----------------------------------------------------------------------------
// fbsc_pkg: shared types and constants of the feedback byte stream cipher
// Holds the keystream constants, controller states and command bundle.
// ----------------------------------------------------------------------------
package fbsc_pkg;

    localparam logic [63:0] STATE_MULT     = 64'd709;
    localparam logic [63:0] STATE_SCRAMBLE = 64'hECD96C09EEFC5F6D;

    // register map, index in units of 8 bytes
    localparam logic        REG_KEY_VALUE  = 1'b0;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MIX
    } fbsc_state_t;

    typedef struct packed {
        logic capture;  // take a transaction, multiply state by 709
        logic commit;   // mix the byte, load the output register
    } fbsc_cmd_t;

endpackage

/* hw/rtl/fbsc_ctrl.sv */
// ----------------------------------------------------------------------------
// fbsc_ctrl: controller of the feedback byte stream cipher
// Sequences capture and commit of one byte and owns the output valid flag.
// ----------------------------------------------------------------------------
module fbsc_ctrl
    import fbsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output fbsc_cmd_t cmd
);

    fbsc_state_t state_reg;
    fbsc_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MIX;
                end
            end
            ST_MIX: begin
                // commit only once the output register is free or draining
                if (!out_valid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* hw/rtl/fbsc_dp.sv */
// ----------------------------------------------------------------------------
// fbsc_dp: datapath of the feedback byte stream cipher
// Holds key state and lane, forms the key byte and the result byte.
// ----------------------------------------------------------------------------
module fbsc_dp
    import fbsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fbsc_cmd_t   cmd,
    input  logic        in_mode,
    input  logic [7:0]  in_data,
    input  logic        in_new_stream,
    input  logic        in_last,
    input  logic [63:0] key_value,
    output logic [7:0]  out_data
);

    logic [63:0] key_state_reg;
    logic [63:0] key_state_next;
    logic [2:0]  lane_reg;
    logic [2:0]  lane_next;

    // captured transaction
    logic [63:0] prod_reg;
    logic [2:0]  cur_lane_reg;
    logic        mode_reg;
    logic        last_reg;
    logic [7:0]  din_reg;
    logic [7:0]  out_data_reg;

    logic [63:0] base_state;
    logic [7:0]  key_byte;
    logic [7:0]  cipher;
    logic [7:0]  result;

    assign base_state = in_new_stream ? key_value : key_state_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            prod_reg     <= base_state * STATE_MULT;
            cur_lane_reg <= in_new_stream ? 3'd0 : lane_reg;
            mode_reg     <= in_mode;
            last_reg     <= in_last;
            din_reg      <= in_data;
        end
        if (cmd.commit) begin
            out_data_reg <= result;
        end
    end

    always_comb begin
        key_byte = prod_reg[{cur_lane_reg, 3'b000} +: 8];
        if (mode_reg) begin
            cipher = din_reg;
            result = din_reg - key_byte;
        end else begin
            cipher = din_reg + key_byte;
            result = cipher;
        end
        key_state_next = key_state_reg;
        lane_next      = lane_reg;
        if (cmd.commit) begin
            key_state_next = prod_reg + ({56'd0, cipher} * STATE_SCRAMBLE);
            lane_next      = last_reg ? 3'd0 : cur_lane_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_state_reg <= '0;
            lane_reg      <= '0;
        end else begin
            key_state_reg <= key_state_next;
            lane_reg      <= lane_next;
        end
    end

    assign out_data = out_data_reg;

endmodule

/* hw/rtl/feedback_byte_stream_cipher_core.sv */
// ----------------------------------------------------------------------------
// feedback_byte_stream_cipher_core: byte stream cipher with 64-bit key state
// Results are registered: an accepted byte is captured, then committed into
// the output register once that register is free or being drained.
// One byte at a time: no new byte is accepted until the last is committed;
// the multiply by 709 and the scramble multiply-add form the state loop.
// Reset: synchronous active-low aresetn clears key, key state, lane, valids.
// ----------------------------------------------------------------------------
module feedback_byte_stream_cipher_core
    import fbsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [1:0]  s_tuser,   // [0] mode, [1] new_stream
    input  logic        s_tlast,   // last_of_buffer

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Key register. Writes land on the access phase; bit 3 of paddr picks
    // the 8-byte register slot, the low bits are don't-care.
    logic [63:0] key_value_reg;
    logic [63:0] key_value_next;
    logic        cfg_write;

    fbsc_cmd_t   cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        key_value_next = key_value_reg;
        if (cfg_write && (paddr[3] == REG_KEY_VALUE)) begin
            key_value_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_value_reg <= '0;
        end else begin
            key_value_reg <= key_value_next;
        end
    end

    // Read back the key; the unused slot reads zero.
    always_comb begin
        prdata = '0;
        if (paddr[3] == REG_KEY_VALUE) begin
            prdata = key_value_reg;
        end
    end

    // Controller: accept one transaction, then commit it into the output
    // register once that register is empty or being drained.
    fbsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: the capture step multiplies the (possibly reloaded) state by
    // 709, the commit step extracts the lane's key byte, adds or subtracts it
    // and folds the ciphertext byte back into the state.
    fbsc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_mode       (s_tuser[0]),
        .in_data       (s_tdata),
        .in_new_stream (s_tuser[1]),
        .in_last       (s_tlast),
        .key_value     (key_value_reg),
        .out_data      (m_tdata)
    );

endmodule

/* hw/rtl/fbsc_chk.sv */
// ----------------------------------------------------------------------------
// fbsc_chk: port checker for the feedback byte stream cipher core
// Watches handshake timing of both streams and binds to the top level.
// ----------------------------------------------------------------------------
module fbsc_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // one byte at a time: busy in the cycle after a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a byte is in flight");

    // with a free output register the result appears with no stall
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
        else $error("result late after input transaction");

    // a new result comes only out of the busy cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready && !$past(s_tready))
        else $error("result appeared without a byte in flight");

endmodule

bind feedback_byte_stream_cipher_core fbsc_chk u_fbsc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for the feedback byte stream cipher core
// Streams plaintext and ciphertext bytes through the core under several
// 64-bit keys and checks every output byte against an in-bench predictor
// of the keystream. Both stream sides idle in random bursts, the result
// side holds off once for a long stretch, and the key register is
// rewritten only while the core is drained.
// ----------------------------------------------------------------------------
module tb_top;
    import fbsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // tuser[0] selects the direction of the byte
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // register map: the index counts in units of 8 bytes
    localparam logic [3:0] KEY_ADDR = {REG_KEY_VALUE, 3'b000};

    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 4;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       fresh;
        logic       last;
    } cipher_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] data_in
    logic [1:0]  s_tuser  = '0;    // [0] mode, [1] new_stream
    logic        s_tlast  = 1'b0;  // last_of_buffer

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] data_out

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic [63:0] prdata;
    logic        pready;

    // bytes waiting to be offered, and output bytes still owed by the core
    cipher_item_t pending_bytes_q[$];
    logic [7:0]   expected_bytes_q[$];

    // bench copy of the key register and of the cipher state
    logic [63:0] key_model   = '0;
    logic [63:0] state_model = '0;
    logic [2:0]  lane_model  = '0;

    int  bad_bytes     = 0;
    bit  idle_on       = 1'b0;
    int  sink_hold_req = 0;

    feedback_byte_stream_cipher_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the bench cipher by one byte and return the byte the core owes.
    // A reload comes before the multiply; the scramble always mixes in the
    // ciphertext side of the byte, whichever the direction.
    function automatic logic [7:0] predict_cipher_byte(input cipher_item_t item);
        logic [7:0] key_byte;
        logic [7:0] cipher_byte;
        logic [7:0] out_byte;
        if (item.fresh) begin
            state_model = key_model;
            lane_model  = '0;
        end
        state_model = state_model * STATE_MULT;
        key_byte    = state_model[lane_model*8 +: 8];
        if (item.mode == MODE_DECRYPT) begin
            cipher_byte = item.data;
            out_byte    = item.data - key_byte;
        end else begin
            cipher_byte = item.data + key_byte;
            out_byte    = cipher_byte;
        end
        state_model = state_model + {56'd0, cipher_byte} * STATE_SCRAMBLE;
        lane_model  = item.last ? 3'd0 : lane_model + 3'd1;
        return out_byte;
    endfunction

    function automatic void queue_byte(input logic mode, input logic [7:0] data,
                                       input logic fresh, input logic last);
        cipher_item_t item;
        item.mode  = mode;
        item.data  = data;
        item.fresh = fresh;
        item.last  = last;
        pending_bytes_q.push_back(item);
    endfunction

    // Build random traffic: mostly well-formed streams (new_stream on the
    // first byte, one to three buffers each closed by tlast, a rare mid-stream
    // direction flip) with some fully random bytes mixed in as noise.
    function automatic void queue_random_traffic(input int n_bytes);
        int   queued;
        int   n_buf;
        int   buf_len;
        logic mode;
        queued = 0;
        while (queued < n_bytes) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                queued++;
            end else begin
                n_buf = $urandom_range(1, 3);
                mode  = 1'($urandom_range(0, 1));
                for (int b = 0; b < n_buf; b++) begin
                    buf_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 19);
                    for (int i = 0; i < buf_len; i++) begin
                        if ($urandom_range(0, 15) == 0)
                            mode = ~mode;
                        queue_byte(mode, 8'($urandom_range(0, 255)),
                                   (b == 0 && i == 0), (i == buf_len - 1));
                        queued++;
                    end
                end
            end
        end
    endfunction

    // Hold until nothing is queued, offered or owed, then let the pipe settle.
    // Check on the falling edge so the sender's and monitor's updates are seen.
    task automatic drain_core();
        while (pending_bytes_q.size() != 0 || s_tvalid || expected_bytes_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write of the key: setup phase, then access phase; the register
    // takes the value at the edge closing the access phase.
    task automatic write_key(input logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        key_model = value;
    endtask

    // Sender: hold a transaction until it is taken, then either idle for a
    // burst or present the next pending byte.
    always @(posedge aclk) begin
        cipher_item_t next_item;
        int           src_gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes_q.size() != 0) begin
                next_item = pending_bytes_q.pop_front();
                s_tdata  <= next_item.data;
                s_tuser  <= {next_item.fresh, next_item.mode};
                s_tlast  <= next_item.last;
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 11);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request that
    // lets the core fill up and push back on its input.
    always @(posedge aclk) begin
        int sink_gap;
        int sink_hold_left;
        int sink_hold_seen;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap       = 0;
            sink_hold_left = 0;
            sink_hold_seen = 0;
        end else if (sink_hold_seen != sink_hold_req) begin
            sink_hold_seen = sink_hold_req;
            sink_hold_left = SINK_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
                sink_gap = $urandom_range(1, 11);
        end
    end

    // Monitor: check each output transaction first, then predict the byte
    // for an input transaction taken at the same edge.
    always @(posedge aclk) begin
        logic [7:0]   want;
        cipher_item_t seen_item;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes_q.size() == 0) begin
                bad_bytes++;
                if (bad_bytes <= MAX_REPORTS)
                    $display("%0t: output byte %02h with nothing expected", $realtime, m_tdata);
            end else begin
                want = expected_bytes_q.pop_front();
                if (m_tdata !== want) begin
                    bad_bytes++;
                    if (bad_bytes <= MAX_REPORTS)
                        $display("%0t: data_out expected %02h, got %02h",
                                 $realtime, want, m_tdata);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            seen_item.mode  = s_tuser[0];
            seen_item.data  = s_tdata;
            seen_item.fresh = s_tuser[1];
            seen_item.last  = s_tlast;
            expected_bytes_q.push_back(predict_cipher_byte(seen_item));
        end
    end

    // Run the phases: directed bytes, then random traffic under several keys.
    initial begin
        logic [63:0] phase_keys[5];
        phase_keys[0] = 64'h0000_0000_0000_0000;
        phase_keys[1] = {$urandom, $urandom};
        phase_keys[2] = 64'h8000_0000_0000_0001;
        phase_keys[3] = {$urandom, $urandom};
        phase_keys[4] = 64'hFFFF_FFFF_FFFF_FFFF;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // No stream started: the state runs from its reset value.
        queue_byte(MODE_ENCRYPT, 8'h00, 1'b0, 1'b0);
        queue_byte(MODE_DECRYPT, 8'hFF, 1'b0, 1'b0);
        queue_byte(MODE_ENCRYPT, 8'hFF, 1'b0, 1'b1);
        queue_byte(MODE_DECRYPT, 8'h00, 1'b0, 1'b0);
        drain_core();

        write_key(64'hFFFF_FFFF_FFFF_FFFF);
        // New stream, then run the lane through a wrap without tlast.
        queue_byte(MODE_ENCRYPT, 8'h00, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
            queue_byte(MODE_ENCRYPT, (i % 2) ? 8'hFF : 8'h5A, 1'b0, 1'b0);
        queue_byte(MODE_ENCRYPT, 8'hA5, 1'b0, 1'b1);
        // Fresh buffer in lane 0, direction flips mid-stream.
        queue_byte(MODE_DECRYPT, 8'h00, 1'b0, 1'b0);
        queue_byte(MODE_DECRYPT, 8'hFF, 1'b0, 1'b0);
        queue_byte(MODE_ENCRYPT, 8'h3C, 1'b0, 1'b0);
        // Both flags on one byte, then a byte that must sit in lane 0.
        queue_byte(MODE_DECRYPT, 8'hFF, 1'b1, 1'b1);
        queue_byte(MODE_ENCRYPT, 8'h00, 1'b0, 1'b0);
        queue_byte(MODE_DECRYPT, 8'h80, 1'b1, 1'b1);
        drain_core();

        for (int p = 0; p < 5; p++) begin
            write_key(phase_keys[p]);
            // keep the closing phase free of idling
            idle_on = (p != 4);
            if (p == 2)
                sink_hold_req <= sink_hold_req + 1;
            queue_random_traffic(150);
            // sender pause: wait for every owed byte before the next key
            drain_core();
        end

        if (expected_bytes_q.size() != 0)
            bad_bytes++;
        if (bad_bytes == 0) begin
            $display("feedback_byte_stream_cipher_core regression: pass");
        end else begin
            $display("feedback_byte_stream_cipher_core regression: fail");
        end
        $finish;
    end

    // Watchdog: generous ceiling on the whole run.
    initial begin
        #(3_000_000);
        $display("feedback_byte_stream_cipher_core regression: fail");
        $finish;
    end

endmodule
